>>> sv/slem_pkg.sv
// ----------------------------------------------------------------------------
// slem_pkg
// Shared types and constants of the shared/exclusive lock manager.
// ----------------------------------------------------------------------------
package slem_pkg;

  // Request codes.
  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_END    = 3'd1;
  localparam logic [2:0] REQ_SHARED = 3'd2;
  localparam logic [2:0] REQ_EXCL   = 3'd3;
  localparam logic [2:0] REQ_UNLOCK = 3'd4;

  // Event codes.
  localparam logic [2:0] KIND_STARTED   = 3'd0;
  localparam logic [2:0] KIND_ENDED     = 3'd1;
  localparam logic [2:0] KIND_GRANTED   = 3'd2;
  localparam logic [2:0] KIND_Q_OWN     = 3'd3;
  localparam logic [2:0] KIND_Q_CONFL   = 3'd4;
  localparam logic [2:0] KIND_UPGRADED  = 3'd5;
  localparam logic [2:0] KIND_RELEASED  = 3'd6;
  localparam logic [2:0] KIND_REJECTED  = 3'd7;

  // Lock modes.
  localparam logic [1:0] MODE_FREE   = 2'd0;
  localparam logic [1:0] MODE_SHARED = 2'd1;
  localparam logic [1:0] MODE_EXCL   = 2'd2;
  localparam logic [1:0] MODE_UPD    = 2'd3;

  // Compatibility of a held mode (first index) with a requested mode (bit).
  localparam logic [0:3] COMPAT [4] = '{4'b1110, 4'b1101, 4'b1000, 4'b1000};

  // Events reported per request at most.
  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W   = 7;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] txn_id;
    logic [4:0] object_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] event_txn;
    logic [4:0] event_object;
    logic [1:0] event_mode;
    logic [7:0] blocker_txn;
    logic       last;
  } out_item_t;

  // Summary of one scanned holder row.
  typedef struct packed {
    logic       grant;
    logic [1:0] got_mode;
    logic       promo_hit;
  } row_res_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DEC,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_END_REL,
    ST_UNL_REL,
    ST_PROMO,
    ST_LCK_ATT,
    ST_FLT_INIT,
    ST_FLT_RD,
    ST_FLT_LD,
    ST_RTY_HEAD,
    ST_RTY_QLD,
    ST_RTY_ATT,
    ST_FIN
  } state_t;

endpackage

>>> sv/slem_ram.sv
// ----------------------------------------------------------------------------
// slem_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module slem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/slem_row_eval.sv
// ----------------------------------------------------------------------------
// slem_row_eval
// Scans one object's holder row for a lock attempt and for promotion.
// ----------------------------------------------------------------------------
module slem_row_eval #(
  parameter int NUM_TXNS = 256,
  parameter int TXN_W    = 8
) (
  input  logic [2*NUM_TXNS-1:0] row,
  input  logic [TXN_W-1:0]      att_txn,
  input  logic [1:0]            att_req,
  output slem_pkg::row_res_t    res,
  output logic [TXN_W-1:0]      blk_idx,
  output logic [TXN_W-1:0]      promo_idx
);

  logic       conflict;
  logic       xu;
  logic       any_sh;
  logic       up_hit;
  logic [1:0] m;
  logic       other;

  // Scanning from the top down leaves the lowest matching index behind.
  always_comb begin
    conflict  = 1'b0;
    xu        = 1'b0;
    any_sh    = 1'b0;
    up_hit    = 1'b0;
    blk_idx   = '0;
    promo_idx = '0;
    m         = '0;
    other     = 1'b0;
    for (int i = NUM_TXNS - 1; i >= 0; i--) begin
      m     = row[2*i +: 2];
      other = (TXN_W'(i) != att_txn);
      if (other && !slem_pkg::COMPAT[m][att_req]) begin
        conflict = 1'b1;
        blk_idx  = TXN_W'(i);
      end
      if (other && m[1]) begin
        xu = 1'b1;
      end
      if (m == slem_pkg::MODE_SHARED) begin
        any_sh = 1'b1;
      end
      if (m == slem_pkg::MODE_UPD) begin
        up_hit    = 1'b1;
        promo_idx = TXN_W'(i);
      end
    end
    res.grant     = !conflict || (att_req == slem_pkg::MODE_EXCL && !xu);
    res.got_mode  = conflict ? slem_pkg::MODE_UPD : att_req;
    res.promo_hit = !any_sh && up_hit;
  end

endmodule

>>> sv/slem_evt_buf.sv
// ----------------------------------------------------------------------------
// slem_evt_buf
// Holds back one event so that the final event of a request carries last.
// ----------------------------------------------------------------------------
module slem_evt_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                em_valid,
  input  slem_pkg::out_item_t em_item,
  input  logic                flush,
  output logic                out_valid,
  output slem_pkg::out_item_t out_item
);

  logic                                pend_valid_r, pend_valid_nxt;
  slem_pkg::out_item_t                 pend_r, pend_nxt;
  logic [slem_pkg::RES_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                                out_valid_r, out_valid_nxt;
  slem_pkg::out_item_t                 out_r, out_nxt;
  logic                                take;

  always_comb begin
    take           = em_valid && (cnt_r < slem_pkg::RES_CNT_W'(slem_pkg::MAX_RESULTS));
    out_nxt        = pend_r;
    out_nxt.last   = flush;
    out_valid_nxt  = pend_valid_r && (take || flush);
    pend_nxt       = take ? em_item : pend_r;
    pend_valid_nxt = take ? 1'b1 : (flush ? 1'b0 : pend_valid_r);
    cnt_nxt        = flush ? '0 : (take ? cnt_r + 1'b1 : cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> sv/shared_exclusive_lock_manager_core.sv
// ----------------------------------------------------------------------------
// shared_exclusive_lock_manager_core
// Lock manager with shared, exclusive and update-pending modes and a FIFO
// wait queue, built round a row-wide lock table memory.
// ----------------------------------------------------------------------------
// Each event is held back in the output buffer until the next event or the close
// of the request, so that the final one carries last. A new request is taken only
// while idle; busy stays high until the current one is finished. An end walks every
// object, releasing what the transaction holds, then drops its queued requests; an
// end or an unlock then retries the wait queue heads while they can be granted.
// Reset runs a clearing pass over the lock table and the waiting counts.
// Events never stall.
module shared_exclusive_lock_manager_core #(
  parameter int NUM_OBJECTS = 26,
  parameter int NUM_TXNS    = 256,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  slem_pkg::in_item_t  in_item,
  output logic                out_valid,
  output slem_pkg::out_item_t out_item
);

  localparam int TXN_W = $clog2(NUM_TXNS);
  localparam int OBJ_W = $clog2(NUM_OBJECTS);
  localparam int Q_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ROW_W = 2 * NUM_TXNS;
  localparam int QE_W  = TXN_W + OBJ_W + 2;
  localparam int CLR_N = (NUM_OBJECTS > NUM_TXNS) ? NUM_OBJECTS : NUM_TXNS;
  localparam int CLR_W = $clog2(CLR_N);

  // Control registers.
  slem_pkg::state_t   state_r, state_nxt;
  slem_pkg::in_item_t req_r;
  logic               retry_r, retry_nxt;
  logic [Q_W-1:0]     hd_r, hd_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [Q_W-1:0]     rp_r, rp_nxt;
  logic [Q_W-1:0]     wp_r, wp_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]   w_r, w_nxt;
  logic [CLR_W-1:0]   clr_r, clr_nxt;

  // Working registers: the current row, waiting count and attempt subject.
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [CNT_W-1:0]   wcnt_r, wcnt_nxt;
  logic [TXN_W-1:0]   h_txn_r, h_txn_nxt;
  logic [OBJ_W-1:0]   h_obj_r, h_obj_nxt;
  logic [1:0]         h_mode_r, h_mode_nxt;

  // Memory ports.
  logic               lk_we;
  logic [OBJ_W-1:0]   lk_waddr;
  logic [ROW_W-1:0]   lk_wdata;
  logic [ROW_W-1:0]   lk_rdata;
  logic               wt_we;
  logic [TXN_W-1:0]   wt_waddr;
  logic [CNT_W-1:0]   wt_wdata;
  logic [CNT_W-1:0]   wt_rdata;
  logic               q_we;
  logic [Q_W-1:0]     q_waddr;
  logic [QE_W-1:0]    q_wdata;
  logic [Q_W-1:0]     q_raddr;
  logic [QE_W-1:0]    q_rdata;

  // Row scan results.
  slem_pkg::row_res_t att;
  logic [TXN_W-1:0]   blk_idx;
  logic [TXN_W-1:0]   promo_idx;

  // Event strobe towards the output buffer.
  logic                em_valid;
  slem_pkg::out_item_t em_item;
  logic                flush;

  // Combinational helpers.
  logic [1:0]         prev_mode;
  logic [ROW_W-1:0]   row_gnt;
  logic [ROW_W-1:0]   row_pro;
  logic [Q_W:0]       tail_sum;
  logic [Q_W-1:0]     tail;
  logic               req_ok;
  logic               keep;
  logic [TXN_W-1:0]   qe_txn;

  function automatic logic [Q_W-1:0] q_inc(input logic [Q_W-1:0] p);
    q_inc = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic slem_pkg::out_item_t mk_evt(
    input logic [2:0] kind,
    input logic [7:0] txn,
    input logic [4:0] obj,
    input logic [1:0] mode,
    input logic [7:0] blk
  );
    slem_pkg::out_item_t e;
    e.event_kind   = kind;
    e.event_txn    = txn;
    e.event_object = obj;
    e.event_mode   = mode;
    e.blocker_txn  = blk;
    e.last         = 1'b0;
    mk_evt = e;
  endfunction

  // The lock table holds one row per object, two bits per transaction, so
  // that a whole holder row is read and written back in one access.
  slem_ram #(.WIDTH(ROW_W), .DEPTH(NUM_OBJECTS)) u_lock_tbl (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (h_obj_r),
    .rdata (lk_rdata)
  );

  // Number of queued requests per transaction.
  slem_ram #(.WIDTH(CNT_W), .DEPTH(NUM_TXNS)) u_wait_cnt (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (wt_wdata),
    .raddr (h_txn_r),
    .rdata (wt_rdata)
  );

  // Wait queue as a ring: entry i lives at (hd + i) modulo the depth.
  slem_ram #(.WIDTH(QE_W), .DEPTH(QUEUE_DEPTH)) u_wait_q (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  slem_row_eval #(.NUM_TXNS(NUM_TXNS), .TXN_W(TXN_W)) u_row_eval (
    .row       (row_r),
    .att_txn   (h_txn_r),
    .att_req   (h_mode_r),
    .res       (att),
    .blk_idx   (blk_idx),
    .promo_idx (promo_idx)
  );

  slem_evt_buf u_evt_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .em_valid  (em_valid),
    .em_item   (em_item),
    .flush     (flush),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign busy    = (state_r != slem_pkg::ST_IDLE);
  assign q_raddr = (state_r == slem_pkg::ST_FLT_RD) ? rp_r : hd_r;

  always_comb begin
    prev_mode = row_r[2*h_txn_r +: 2];
    row_gnt   = row_r;
    row_gnt[2*h_txn_r +: 2] = att.got_mode;
    row_pro   = row_r;
    if (att.promo_hit) begin
      row_pro[2*promo_idx +: 2] = slem_pkg::MODE_EXCL;
    end
    tail_sum = (Q_W+1)'(hd_r) + (Q_W+1)'(fill_r);
    tail     = (32'(tail_sum) >= QUEUE_DEPTH) ? Q_W'(32'(tail_sum) - QUEUE_DEPTH)
                                              : Q_W'(tail_sum);
    req_ok   = (req_r.req_type <= slem_pkg::REQ_UNLOCK) &&
               (32'(req_r.txn_id) < NUM_TXNS) &&
               ((req_r.req_type < slem_pkg::REQ_SHARED) ||
                (32'(req_r.object_index) < NUM_OBJECTS));
    qe_txn   = q_rdata[QE_W-1 -: TXN_W];
    keep     = (qe_txn != h_txn_r);
  end

  // Main sequencer.
  always_comb begin
    state_nxt  = state_r;
    retry_nxt  = retry_r;
    hd_nxt     = hd_r;
    fill_nxt   = fill_r;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    k_nxt      = k_r;
    w_nxt      = w_r;
    clr_nxt    = clr_r;
    row_nxt    = row_r;
    wcnt_nxt   = wcnt_r;
    h_txn_nxt  = h_txn_r;
    h_obj_nxt  = h_obj_r;
    h_mode_nxt = h_mode_r;
    lk_we      = 1'b0;
    lk_waddr   = h_obj_r;
    lk_wdata   = row_gnt;
    wt_we      = 1'b0;
    wt_waddr   = h_txn_r;
    wt_wdata   = '0;
    q_we       = 1'b0;
    q_waddr    = tail;
    q_wdata    = {h_txn_r, h_obj_r, h_mode_r};
    em_valid   = 1'b0;
    em_item    = mk_evt(slem_pkg::KIND_STARTED, 8'(h_txn_r), 5'(h_obj_r), h_mode_r, 8'd0);
    flush      = 1'b0;

    unique case (state_r)
      slem_pkg::ST_CLR: begin
        // Clearing pass over the lock table and the waiting counts.
        lk_we    = (32'(clr_r) < NUM_OBJECTS);
        lk_waddr = OBJ_W'(clr_r);
        lk_wdata = '0;
        wt_we    = (32'(clr_r) < NUM_TXNS);
        wt_waddr = TXN_W'(clr_r);
        wt_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
        if (32'(clr_r) == CLR_N - 1) begin
          state_nxt = slem_pkg::ST_IDLE;
        end
      end

      slem_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = slem_pkg::ST_DEC;
        end
      end

      slem_pkg::ST_DEC: begin
        retry_nxt  = 1'b0;
        h_txn_nxt  = TXN_W'(req_r.txn_id);
        h_obj_nxt  = (req_r.req_type == slem_pkg::REQ_END) ? '0
                                                          : OBJ_W'(req_r.object_index);
        h_mode_nxt = (req_r.req_type == slem_pkg::REQ_EXCL) ? slem_pkg::MODE_EXCL
                                                            : slem_pkg::MODE_SHARED;
        if (!req_ok) begin
          state_nxt = slem_pkg::ST_FIN;
        end else if (req_r.req_type == slem_pkg::REQ_START) begin
          em_valid  = 1'b1;
          em_item   = mk_evt(slem_pkg::KIND_STARTED, req_r.txn_id, 5'd0,
                             slem_pkg::MODE_FREE, 8'd0);
          state_nxt = slem_pkg::ST_FIN;
        end else begin
          if (req_r.req_type == slem_pkg::REQ_END) begin
            em_valid = 1'b1;
            em_item  = mk_evt(slem_pkg::KIND_ENDED, req_r.txn_id, 5'd0,
                              slem_pkg::MODE_FREE, 8'd0);
          end
          state_nxt = slem_pkg::ST_ROW_RD;
        end
      end

      slem_pkg::ST_ROW_RD: begin
        // Both memories are addressed by the working registers.
        state_nxt = slem_pkg::ST_ROW_LD;
      end

      slem_pkg::ST_ROW_LD: begin
        row_nxt  = lk_rdata;
        wcnt_nxt = wt_rdata;
        if (retry_r) begin
          state_nxt = slem_pkg::ST_RTY_ATT;
        end else if (req_r.req_type == slem_pkg::REQ_END) begin
          state_nxt = slem_pkg::ST_END_REL;
        end else if (req_r.req_type == slem_pkg::REQ_UNLOCK) begin
          state_nxt = slem_pkg::ST_UNL_REL;
        end else begin
          state_nxt = slem_pkg::ST_LCK_ATT;
        end
      end

      slem_pkg::ST_END_REL: begin
        if (prev_mode != slem_pkg::MODE_FREE) begin
          em_valid = 1'b1;
          em_item  = mk_evt(slem_pkg::KIND_RELEASED, 8'(h_txn_r), 5'(h_obj_r),
                            prev_mode, 8'd0);
          row_nxt[2*h_txn_r +: 2] = slem_pkg::MODE_FREE;
          state_nxt = slem_pkg::ST_PROMO;
        end else if (32'(h_obj_r) == NUM_OBJECTS - 1) begin
          state_nxt = slem_pkg::ST_FLT_INIT;
        end else begin
          h_obj_nxt = h_obj_r + 1'b1;
          state_nxt = slem_pkg::ST_ROW_RD;
        end
      end

      slem_pkg::ST_UNL_REL: begin
        // An unlock without a lock still reports a release of mode free.
        em_valid = 1'b1;
        em_item  = mk_evt(slem_pkg::KIND_RELEASED, 8'(h_txn_r), 5'(h_obj_r),
                          prev_mode, 8'd0);
        row_nxt[2*h_txn_r +: 2] = slem_pkg::MODE_FREE;
        state_nxt = slem_pkg::ST_PROMO;
      end

      slem_pkg::ST_PROMO: begin
        // Write the released row back, promoting the lowest update-pending
        // holder once no shared holder is left.
        lk_we    = 1'b1;
        lk_wdata = row_pro;
        if (att.promo_hit) begin
          em_valid = 1'b1;
          em_item  = mk_evt(slem_pkg::KIND_UPGRADED, 8'(promo_idx), 5'(h_obj_r),
                            slem_pkg::MODE_EXCL, 8'd0);
        end
        if (req_r.req_type != slem_pkg::REQ_END) begin
          state_nxt = slem_pkg::ST_RTY_HEAD;
        end else if (32'(h_obj_r) == NUM_OBJECTS - 1) begin
          state_nxt = slem_pkg::ST_FLT_INIT;
        end else begin
          h_obj_nxt = h_obj_r + 1'b1;
          state_nxt = slem_pkg::ST_ROW_RD;
        end
      end

      slem_pkg::ST_LCK_ATT: begin
        state_nxt = slem_pkg::ST_FIN;
        if (wcnt_r == '0 && att.grant) begin
          lk_we    = 1'b1;
          em_valid = 1'b1;
          em_item  = mk_evt(slem_pkg::KIND_GRANTED, 8'(h_txn_r), 5'(h_obj_r),
                            att.got_mode, 8'd0);
        end else if (32'(fill_r) >= QUEUE_DEPTH) begin
          em_valid = 1'b1;
          em_item  = mk_evt(slem_pkg::KIND_REJECTED, 8'(h_txn_r), 5'(h_obj_r),
                            h_mode_r, 8'd0);
        end else begin
          // Own waits queue without a check; otherwise the lowest blocker goes out.
          q_we     = 1'b1;
          fill_nxt = fill_r + 1'b1;
          wt_we    = 1'b1;
          wt_wdata = wcnt_r + 1'b1;
          em_valid = 1'b1;
          if (wcnt_r != '0) begin
            em_item = mk_evt(slem_pkg::KIND_Q_OWN, 8'(h_txn_r), 5'(h_obj_r),
                             h_mode_r, 8'd0);
          end else begin
            em_item = mk_evt(slem_pkg::KIND_Q_CONFL, 8'(h_txn_r), 5'(h_obj_r),
                             h_mode_r, 8'(blk_idx));
          end
        end
      end

      slem_pkg::ST_FLT_INIT: begin
        // The ending transaction's queued requests are dropped by compacting
        // the ring in place.
        wt_we     = 1'b1;
        wt_wdata  = '0;
        rp_nxt    = hd_r;
        wp_nxt    = hd_r;
        k_nxt     = '0;
        w_nxt     = '0;
        state_nxt = (fill_r == '0) ? slem_pkg::ST_RTY_HEAD : slem_pkg::ST_FLT_RD;
      end

      slem_pkg::ST_FLT_RD: begin
        state_nxt = slem_pkg::ST_FLT_LD;
      end

      slem_pkg::ST_FLT_LD: begin
        q_waddr = wp_r;
        q_wdata = q_rdata;
        if (keep) begin
          q_we   = 1'b1;
          wp_nxt = q_inc(wp_r);
        end
        w_nxt  = w_r + CNT_W'(keep);
        rp_nxt = q_inc(rp_r);
        k_nxt  = k_r + 1'b1;
        if (k_r + 1'b1 == fill_r) begin
          fill_nxt  = w_r + CNT_W'(keep);
          state_nxt = slem_pkg::ST_RTY_HEAD;
        end else begin
          state_nxt = slem_pkg::ST_FLT_RD;
        end
      end

      slem_pkg::ST_RTY_HEAD: begin
        if (fill_r == '0) begin
          state_nxt = slem_pkg::ST_FIN;
        end else begin
          retry_nxt = 1'b1;
          state_nxt = slem_pkg::ST_RTY_QLD;
        end
      end

      slem_pkg::ST_RTY_QLD: begin
        h_txn_nxt  = qe_txn;
        h_obj_nxt  = q_rdata[2 +: OBJ_W];
        h_mode_nxt = q_rdata[1:0];
        state_nxt  = slem_pkg::ST_ROW_RD;
      end

      slem_pkg::ST_RTY_ATT: begin
        if (att.grant) begin
          lk_we    = 1'b1;
          em_valid = 1'b1;
          em_item  = mk_evt(slem_pkg::KIND_GRANTED, 8'(h_txn_r), 5'(h_obj_r),
                            att.got_mode, 8'd0);
          hd_nxt   = q_inc(hd_r);
          fill_nxt = fill_r - 1'b1;
          if (wcnt_r != '0) begin
            wt_we    = 1'b1;
            wt_wdata = wcnt_r - 1'b1;
          end
          state_nxt = slem_pkg::ST_RTY_HEAD;
        end else begin
          // A head that cannot be granted stops the retry.
          state_nxt = slem_pkg::ST_FIN;
        end
      end

      slem_pkg::ST_FIN: begin
        flush     = 1'b1;
        state_nxt = slem_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = slem_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slem_pkg::ST_CLR;
      retry_r <= 1'b0;
      hd_r    <= '0;
      fill_r  <= '0;
      rp_r    <= '0;
      wp_r    <= '0;
      k_r     <= '0;
      w_r     <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      retry_r <= retry_nxt;
      hd_r    <= hd_nxt;
      fill_r  <= fill_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      k_r     <= k_nxt;
      w_r     <= w_nxt;
      clr_r   <= clr_nxt;
    end
    if (state_r == slem_pkg::ST_IDLE && start) begin
      req_r <= in_item;
    end
    row_r    <= row_nxt;
    wcnt_r   <= wcnt_nxt;
    h_txn_r  <= h_txn_nxt;
    h_obj_r  <= h_obj_nxt;
    h_mode_r <= h_mode_nxt;
  end

  // The queue never holds more entries than it has room for.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= QUEUE_DEPTH)
    else $error("wait queue fill exceeds depth");

  // The ring head always points inside the queue.
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(hd_r) < QUEUE_DEPTH)
    else $error("wait queue head out of range");

  // An accepted item is decoded in the following cycle.
  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == slem_pkg::ST_DEC))
    else $error("accepted item not decoded");

  // No event leaves the block during the clearing pass.
  a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slem_pkg::ST_CLR) |-> !out_valid)
    else $error("event during clearing pass");

endmodule
